FILE: src/tsp_pkg.sv
package tsp_pkg;

    // parse phase codes
    localparam logic [3:0] PH_IGNORE = 4'd0;
    localparam logic [3:0] PH_HR1    = 4'd1;
    localparam logic [3:0] PH_HR2    = 4'd2;
    localparam logic [3:0] PH_HRSEP  = 4'd3;
    localparam logic [3:0] PH_MN1    = 4'd4;
    localparam logic [3:0] PH_MN2    = 4'd5;
    localparam logic [3:0] PH_AMPM   = 4'd6;
    localparam logic [3:0] PH_LOSEM  = 4'd7;
    localparam logic [3:0] PH_LOOKSP = 4'd8;
    localparam logic [3:0] PH_LOSESP = 4'd9;
    localparam logic [3:0] PH_STORE  = 4'd10;

    // result kinds
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [6:0] HOUR_LIMIT   = 7'd24;
    localparam logic [6:0] MINUTE_LIMIT = 7'd60;
    localparam logic [6:0] NOON         = 7'd12;

    // character codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_LO_P  = 8'h70;
    localparam logic [7:0] CH_UP_P  = 8'h50;
    localparam logic [7:0] CH_LO_M  = 8'h6D;
    localparam logic [7:0] CH_UP_M  = 8'h4D;

    typedef struct packed {
        logic [3:0] phase;
        logic [6:0] hour;
        logic [6:0] minute;
    } t_state;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] text_char;
        logic [4:0] hour;
        logic [5:0] minute;
    } t_result;

endpackage

FILE: src/tsp_step.sv
module tsp_step (
    input  tsp_pkg::t_state  i_state,
    input  logic [7:0]       i_char,
    input  logic             i_eoi,
    output tsp_pkg::t_state  o_state,
    output tsp_pkg::t_result o_result
);

    logic       is_dig;
    logic       is_blank;
    logic       is_nl;
    logic       is_sep;
    logic [6:0] dval;
    logic       at_hr2;
    logic       at_sep;
    logic       at_mn1;
    logic       at_ampm;
    logic       at_losem;
    logic       rej_phase;
    tsp_pkg::t_result emit_res;

    assign is_dig   = (i_char >= tsp_pkg::CH_ZERO) && (i_char <= tsp_pkg::CH_NINE);
    assign is_blank = (i_char == tsp_pkg::CH_SPACE) || (i_char == tsp_pkg::CH_TAB);
    assign is_nl    = (i_char == tsp_pkg::CH_NL);
    assign is_sep   = (i_char == tsp_pkg::CH_COLON) || (i_char == tsp_pkg::CH_DOT);
    assign dval     = {3'b000, i_char[3:0]};

    // phases that fall into the later checks of the spec chain
    assign at_hr2   = (i_state.phase == tsp_pkg::PH_HR2);
    assign at_sep   = at_hr2 || (i_state.phase == tsp_pkg::PH_HRSEP);
    assign at_mn1   = at_sep || (i_state.phase == tsp_pkg::PH_MN1);
    assign at_ampm  = at_mn1 || (i_state.phase == tsp_pkg::PH_AMPM);
    assign at_losem = at_ampm || (i_state.phase == tsp_pkg::PH_LOSEM);

    // on a bad line: newline restarts, anything else skips to the newline
    assign rej_phase = is_nl;

    // text or completion item built from the current accumulators
    always_comb begin
        emit_res.valid     = 1'b1;
        emit_res.kind      = is_nl ? tsp_pkg::KIND_DONE : tsp_pkg::KIND_TEXT;
        emit_res.text_char = is_nl ? 8'h00 : i_char;
        emit_res.hour      = i_state.hour[4:0];
        emit_res.minute    = i_state.minute[5:0];
    end

    always_comb begin
        o_state  = i_state;
        o_result = emit_res;
        o_result.valid = 1'b0;

        if (i_eoi) begin
            if (i_state.phase == tsp_pkg::PH_STORE) begin
                o_result      = emit_res;
                o_result.kind = tsp_pkg::KIND_DONE;
                o_result.text_char = 8'h00;
            end
            o_state.phase  = tsp_pkg::PH_HR1;
            o_state.hour   = 7'd0;
            o_state.minute = 7'd0;
        end else begin
            case (i_state.phase)
                tsp_pkg::PH_IGNORE: begin
                    if (is_nl) begin
                        o_state.phase = tsp_pkg::PH_HR1;
                    end
                end
                tsp_pkg::PH_STORE, tsp_pkg::PH_LOSESP: begin
                    if (i_state.phase == tsp_pkg::PH_LOSESP && is_blank) begin
                        o_state.phase = tsp_pkg::PH_LOSESP;
                    end else if (is_nl) begin
                        o_result       = emit_res;
                        o_state.phase  = tsp_pkg::PH_HR1;
                        o_state.hour   = 7'd0;
                        o_state.minute = 7'd0;
                    end else begin
                        o_result      = emit_res;
                        o_state.phase = tsp_pkg::PH_STORE;
                    end
                end
                tsp_pkg::PH_HR2, tsp_pkg::PH_HRSEP, tsp_pkg::PH_MN1, tsp_pkg::PH_MN2,
                tsp_pkg::PH_AMPM, tsp_pkg::PH_LOSEM, tsp_pkg::PH_LOOKSP: begin
                    if (at_hr2 && is_dig) begin
                        // hour below ten here, so the product stays in 7 bits
                        o_state.hour  = {i_state.hour[3:0], 3'b000}
                                      + {i_state.hour[5:0], 1'b0} + dval;
                        o_state.phase = tsp_pkg::PH_HRSEP;
                    end else if (at_sep && is_sep) begin
                        o_state.phase = tsp_pkg::PH_MN1;
                    end else if (at_mn1 && is_dig) begin
                        o_state.minute = dval;
                        o_state.phase  = tsp_pkg::PH_MN2;
                    end else if (i_state.phase == tsp_pkg::PH_MN2) begin
                        if (is_dig) begin
                            o_state.minute = {i_state.minute[3:0], 3'b000}
                                           + {i_state.minute[5:0], 1'b0} + dval;
                            o_state.phase  = tsp_pkg::PH_AMPM;
                        end else begin
                            // single minute digit
                            o_state.phase = rej_phase ? tsp_pkg::PH_HR1
                                                      : tsp_pkg::PH_IGNORE;
                        end
                    end else if (at_ampm && (i_char == tsp_pkg::CH_LO_A
                                             || i_char == tsp_pkg::CH_UP_A)) begin
                        if (i_state.hour == tsp_pkg::NOON) begin
                            o_state.hour = 7'd0;
                        end
                        o_state.phase = tsp_pkg::PH_LOSEM;
                    end else if (at_ampm && (i_char == tsp_pkg::CH_LO_P
                                             || i_char == tsp_pkg::CH_UP_P)) begin
                        if (i_state.hour < tsp_pkg::NOON) begin
                            o_state.hour = i_state.hour + tsp_pkg::NOON;
                        end
                        o_state.phase = tsp_pkg::PH_LOSEM;
                    end else if (at_losem && (i_char == tsp_pkg::CH_LO_M
                                              || i_char == tsp_pkg::CH_UP_M)) begin
                        o_state.phase = tsp_pkg::PH_LOOKSP;
                    end else if (is_blank) begin
                        if (i_state.hour >= tsp_pkg::HOUR_LIMIT
                            || i_state.minute >= tsp_pkg::MINUTE_LIMIT) begin
                            o_state.phase = tsp_pkg::PH_IGNORE;
                        end else begin
                            o_state.phase = tsp_pkg::PH_LOSESP;
                        end
                    end else begin
                        o_state.phase = rej_phase ? tsp_pkg::PH_HR1 : tsp_pkg::PH_IGNORE;
                    end
                end
                default: begin
                    // first hour digit expected
                    if (is_dig) begin
                        o_state.hour   = dval;
                        o_state.minute = 7'd0;
                        o_state.phase  = tsp_pkg::PH_HR2;
                    end else begin
                        o_state.phase = rej_phase ? tsp_pkg::PH_HR1 : tsp_pkg::PH_IGNORE;
                    end
                end
            endcase
        end
    end

endmodule

FILE: src/time_spec_line_parser_unit.sv
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+-----------------------------------------------
// s_*      | in  | s_tvalid/s_tready  | s_tdata = char_code, s_tlast = end_of_input
// m_*      | out | m_tvalid/m_tready  | m_tuser = kind, m_tdata = text_char,hour,minute
//
// one request per cycle on the input while s_tready is high; each request gives zero or one result
// the parse state updates in the accept cycle and the result lands in the
// output register, seen on m_* in the next cycle
// s_tready is low only while the output register is full and m_tready is low
// synchronous active-low reset puts the parser at line start, output empty
module time_spec_line_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] text_char, [12:8] hour, [18:13] minute, zero pad
    output logic        m_tuser    // kind: 0 text character, 1 record complete
);

    tsp_pkg::t_state  r_state;
    tsp_pkg::t_state  n_state;
    tsp_pkg::t_result step_res;
    logic             r_valid;
    logic             r_kind;
    logic [7:0]       r_char;
    logic [4:0]       r_hour;
    logic [5:0]       r_minute;
    logic             acc;

    // output register free or emptying this cycle
    assign s_tready = !r_valid || m_tready;
    assign acc      = s_tvalid && s_tready;

    tsp_step u_step (
        .i_state  (r_state),
        .i_char   (s_tdata),
        .i_eoi    (s_tlast),
        .o_state  (n_state),
        .o_result (step_res)
    );

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase  <= tsp_pkg::PH_HR1;
            r_state.hour   <= 7'd0;
            r_state.minute <= 7'd0;
        end else if (acc) begin
            r_state <= n_state;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (acc && step_res.valid) begin
            r_valid <= 1'b1;
        end else if (m_tready) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (acc && step_res.valid) begin
            r_kind   <= step_res.kind;
            r_char   <= step_res.text_char;
            r_hour   <= step_res.hour;
            r_minute <= step_res.minute;
        end
    end

    assign m_tvalid = r_valid;
    assign m_tuser  = r_kind;
    assign m_tdata  = {5'd0, r_minute, r_hour, r_char};

    // end of input always brings the parser back to line start
    a_eoi_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && s_tlast) |=> (r_state.phase == tsp_pkg::PH_HR1
                              && r_state.hour == 7'd0 && r_state.minute == 7'd0))
        else $error("parser not at line start after end of input");

    // the text part is only reached with a checked time
    a_store_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == tsp_pkg::PH_STORE || r_state.phase == tsp_pkg::PH_LOSESP)
        |-> (r_state.hour < tsp_pkg::HOUR_LIMIT
             && r_state.minute < tsp_pkg::MINUTE_LIMIT))
        else $error("text part entered with out-of-range time");

    // every result carries a valid time
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_hour < 5'd24 && r_minute < 6'd60))
        else $error("result with out-of-range time");

    // completion items carry no text byte
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == tsp_pkg::KIND_DONE) |-> (r_char == 8'h00))
        else $error("completion item with text byte");

    // a held result is not dropped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !m_tready) |=> r_valid)
        else $error("pending result lost");

endmodule

FILE: tb/tsp_line_checker.sv
module tsp_line_checker
    import tsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] char_code
    input  logic        i_s_tlast,    // end_of_input
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,    // [7:0] text_char, [12:8] hour, [18:13] minute, zero pad
    input  logic        i_m_tuser,    // kind
    output int          o_fail_count,
    output int          o_pending,
    output int          o_text_count,
    output int          o_record_count
);

    // predicted parser state
    logic [3:0] phase;
    logic [6:0] hour_acc;
    logic [6:0] minute_acc;

    t_result pending_results[$];

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic t_result make_result(input logic kind, input logic [7:0] ch);
        t_result r;
        r.valid     = 1'b1;
        r.kind      = kind;
        r.text_char = ch;
        r.hour      = hour_acc[4:0];
        r.minute    = minute_acc[5:0];
        return r;
    endfunction

    // bad line: skip to newline, or start over right away if this is the newline
    task automatic skip_line(input logic [7:0] c);
        phase = (c == CH_NL) ? PH_HR1 : PH_IGNORE;
    endtask

    task automatic clear_parser();
        phase      = PH_HR1;
        hour_acc   = '0;
        minute_acc = '0;
    endtask

    // one accepted request: update the parser and queue what it should emit
    task automatic advance_parser(input logic [7:0] c, input logic eoi);
        logic [3:0] ph;
        bit         done;
        ph   = phase;
        done = 1'b0;
        if (eoi) begin
            if (ph == PH_STORE)
                pending_results.push_back(make_result(KIND_DONE, 8'h00));
            clear_parser();
        end else if (ph == PH_IGNORE) begin
            if (c == CH_NL)
                phase = PH_HR1;
        end else if (ph < PH_HR2 || ph > PH_STORE) begin
            if (is_digit(c)) begin
                hour_acc   = 7'(c - CH_ZERO);
                minute_acc = '0;
                phase      = PH_HR2;
            end else begin
                skip_line(c);
            end
        end else begin
            // later phases accept everything an earlier one would, in order
            if (ph == PH_HR2 && is_digit(c)) begin
                hour_acc = 7'(hour_acc * 10 + (c - CH_ZERO));
                phase    = PH_HRSEP;
                done     = 1'b1;
            end
            if (!done && ph <= PH_HRSEP && (c == CH_COLON || c == CH_DOT)) begin
                phase = PH_MN1;
                done  = 1'b1;
            end
            if (!done && ph <= PH_MN1 && is_digit(c)) begin
                minute_acc = 7'(c - CH_ZERO);
                phase      = PH_MN2;
                done       = 1'b1;
            end
            if (!done && ph <= PH_MN2) begin
                if (is_digit(c)) begin
                    minute_acc = 7'(minute_acc * 10 + (c - CH_ZERO));
                    phase      = PH_AMPM;
                    done       = 1'b1;
                end else if (ph == PH_MN2) begin
                    skip_line(c);
                    done = 1'b1;
                end
            end
            if (!done && ph <= PH_AMPM) begin
                if (c == CH_LO_A || c == CH_UP_A) begin
                    if (hour_acc == NOON)
                        hour_acc = '0;
                    phase = PH_LOSEM;
                    done  = 1'b1;
                end else if (c == CH_LO_P || c == CH_UP_P) begin
                    if (hour_acc < NOON)
                        hour_acc = hour_acc + NOON;
                    phase = PH_LOSEM;
                    done  = 1'b1;
                end
            end
            if (!done && ph <= PH_LOSEM && (c == CH_LO_M || c == CH_UP_M)) begin
                phase = PH_LOOKSP;
                done  = 1'b1;
            end
            if (!done && ph <= PH_LOOKSP) begin
                if (!is_blank(c))
                    skip_line(c);
                else if (hour_acc >= HOUR_LIMIT || minute_acc >= MINUTE_LIMIT)
                    phase = PH_IGNORE;
                else
                    phase = PH_LOSESP;
                done = 1'b1;
            end
            if (!done && ph == PH_LOSESP) begin
                if (is_blank(c))
                    done = 1'b1;
                else
                    phase = PH_STORE;
            end
            if (!done) begin
                if (c == CH_NL) begin
                    pending_results.push_back(make_result(KIND_DONE, 8'h00));
                    clear_parser();
                end else begin
                    pending_results.push_back(make_result(KIND_TEXT, c));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            clear_parser();
            pending_results.delete();
            o_fail_count   = 0;
            o_text_count   = 0;
            o_record_count = 0;
        end else begin
            // results at this edge come from earlier requests, so compare first
            if (i_m_tvalid && i_m_tready) begin
                if (i_m_tuser === KIND_DONE)
                    o_record_count++;
                else
                    o_text_count++;
                if (pending_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result kind=%0d char=%02h hour=%0d minute=%0d",
                                 $time, i_m_tuser, i_m_tdata[7:0], i_m_tdata[12:8],
                                 i_m_tdata[18:13]);
                end else begin
                    want = pending_results.pop_front();
                    if (i_m_tuser !== want.kind || i_m_tdata[7:0] !== want.text_char ||
                        i_m_tdata[12:8] !== want.hour || i_m_tdata[18:13] !== want.minute ||
                        i_m_tdata[23:19] !== 5'd0) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("%0t: mismatch, expected kind=%0d char=%02h hour=%0d minute=%0d",
                                     $time, want.kind, want.text_char, want.hour, want.minute);
                            $display("    got kind=%0d char=%02h hour=%0d minute=%0d pad=%02h",
                                     i_m_tuser, i_m_tdata[7:0], i_m_tdata[12:8],
                                     i_m_tdata[18:13], i_m_tdata[23:19]);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                advance_parser(i_s_tdata, i_s_tlast);
        end
        o_pending = pending_results.size();
    end

endmodule

FILE: tb/time_spec_line_parser_unit_tb.sv
module time_spec_line_parser_unit_tb;
    import tsp_pkg::*;

    // stimulus size and timing limits
    localparam int ITEM_TARGET  = 1650;
    localparam int HOLD_AT      = 500;     // long receiver hold-off starts here
    localparam int PAUSE_AT     = 900;     // sender waits for a full drain here
    localparam int QUIET_AT     = 1400;    // no idling on either side from here on
    localparam int LONG_HOLD    = 300;
    localparam int FILL_CHARS   = 40;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] char_code
    logic        s_tlast;   // end_of_input
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] text_char, [12:8] hour, [18:13] minute, zero pad
    logic        m_tuser;   // kind

    int fail_count;
    int pending;
    int text_count;
    int record_count;
    int items_sent;

    // idling controls shared between sender and receiver
    bit send_gaps;
    bit recv_gaps;
    bit hold_long;

    time_spec_line_parser_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // watches both channels, predicts the parser and compares results
    tsp_line_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tlast      (s_tlast),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tuser      (m_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_text_count   (text_count),
        .o_record_count (record_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // one request, with an optional idle burst in front of it
    // enters and leaves on a falling edge
    task automatic send_item(input logic [7:0] c, input logic eoi);
        int gap;
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eoi;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string txt);
        for (int k = 0; k < txt.len(); k++)
            send_item(txt[k], 1'b0);
    endtask

    // sender goes quiet until every predicted result has been seen
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge i_clk);
        while (pending != 0);
    endtask

    // mostly well-formed time lines with random content, some broken, some noise
    task automatic send_random_line();
        logic [7:0] line_buf[$];
        logic [7:0] ch;
        int         pick;
        int         hour_val;
        int         minute_val;
        int         sep_pick;
        int         mark_pick;
        int         n;
        bit         two_digits;
        bit         with_minutes;
        bit         close_eoi;
        pick      = $urandom_range(0, 99);
        close_eoi = ($urandom_range(0, 15) == 0);
        if (pick < 10) begin
            // noise line, may run on into the next one
            n = $urandom_range(1, 12);
            repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                line_buf.push_back(CH_NL);
        end else begin
            hour_val     = (pick < 85) ? $urandom_range(0, 23) : $urandom_range(0, 99);
            minute_val   = (pick < 90) ? $urandom_range(0, 59) : $urandom_range(0, 99);
            two_digits   = (hour_val >= 10) || ($urandom_range(0, 3) == 0);
            with_minutes = ($urandom_range(0, 3) != 0);
            sep_pick     = $urandom_range(0, 2);
            // a lone hour digit run straight into minutes reads as a two-digit hour
            if (!two_digits && with_minutes && sep_pick == 0 && $urandom_range(0, 7) != 0)
                sep_pick = 1;
            if (two_digits)
                line_buf.push_back(CH_ZERO + 8'(hour_val / 10));
            line_buf.push_back(CH_ZERO + 8'(hour_val % 10));
            if (sep_pick == 1)
                line_buf.push_back(CH_COLON);
            else if (sep_pick == 2)
                line_buf.push_back(CH_DOT);
            if (with_minutes) begin
                line_buf.push_back(CH_ZERO + 8'(minute_val / 10));
                // now and then a lone minute digit, which kills the line
                if ($urandom_range(0, 19) != 0)
                    line_buf.push_back(CH_ZERO + 8'(minute_val % 10));
            end
            mark_pick = $urandom_range(0, 5);
            if (mark_pick == 2)
                line_buf.push_back(CH_LO_A);
            else if (mark_pick == 3)
                line_buf.push_back(CH_UP_A);
            else if (mark_pick == 4)
                line_buf.push_back(CH_LO_P);
            else if (mark_pick == 5)
                line_buf.push_back(CH_UP_P);
            if (mark_pick >= 2 || $urandom_range(0, 4) == 0)
                line_buf.push_back($urandom_range(0, 1) ? CH_LO_M : CH_UP_M);
            // closing blanks, occasionally replaced by a stray byte
            if ($urandom_range(0, 19) == 0) begin
                line_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                n = $urandom_range(1, 3);
                repeat (n) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            end
            // remainder text, printable half the time, any byte but newline otherwise
            n = $urandom_range(0, 8);
            repeat (n) begin
                if ($urandom_range(0, 1))
                    ch = 8'($urandom_range(8'h20, 8'h7E));
                else
                    ch = 8'($urandom_range(0, 255));
                if (ch == CH_NL)
                    ch = CH_SPACE;
                line_buf.push_back(ch);
            end
            if (!close_eoi)
                line_buf.push_back(CH_NL);
        end
        foreach (line_buf[k])
            send_item(line_buf[k], 1'b0);
        if (close_eoi)
            send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_long = 1'b0;
            end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ends the run if no request and no result moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        bit hold_done;
        bit pause_done;
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tlast    = 1'b0;
        items_sent = 0;
        send_gaps  = 1'b1;
        recv_gaps  = 1'b1;
        hold_long  = 1'b0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed lines
        send_text("1234 \n");          // four digits as hh mm, no remainder text
        send_text("9:5\n");            // lone minute digit drops the line
        send_text("12am\t");           // 12am is hour 0, tab closes the spec
        send_item(8'h00, 1'b0);        // byte zero and top byte pass as text
        send_item(8'hFF, 1'b0);
        send_item(8'hA5, 1'b1);        // end of input inside text closes the record
        send_text("25 \n");            // hour out of range, line skipped
        send_text("3P a\n");           // pm shift, one text byte
        send_text("7");
        send_item(8'h5A, 1'b1);        // end of input mid-spec, nothing emitted
        wait_drained();

        // random lines
        while (items_sent < ITEM_TARGET) begin
            if (!hold_done && items_sent >= HOLD_AT) begin
                // receiver sits idle while a long text line keeps coming
                hold_done = 1'b1;
                hold_long = 1'b1;
                send_text("7:15pm ");
                repeat (FILL_CHARS) send_item(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
                send_item(CH_NL, 1'b0);
            end
            if (!pause_done && items_sent >= PAUSE_AT) begin
                pause_done = 1'b1;
                wait_drained();
            end
            if (items_sent >= QUIET_AT) begin
                send_gaps = 1'b0;
                recv_gaps = 1'b0;
            end
            send_random_line();
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("sent %0d input bytes; checked %0d text bytes and %0d completed records",
                 items_sent, text_count, record_count);
        $display("run included a %0d-cycle output hold-off and a full drain pause", LONG_HOLD);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
src/tsp_pkg.sv
src/tsp_step.sv
src/time_spec_line_parser_unit.sv
tb/tsp_line_checker.sv
tb/time_spec_line_parser_unit_tb.sv
